// ===== hdl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, constants and edge setup for the triangle plane slice core
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

    localparam int DIV_STEPS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_LANES = 4;

    localparam logic [0:0] REG_SLICE_HEIGHT = 1'b0;

    typedef struct packed {
        logic [31:0] base;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] t;
        logic [31:0] dz;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic                  crosses;
    } t_item;

    typedef struct packed {
        logic [31:0] base;
        logic        neg;
        logic [31:0] dz;
        logic [63:0] prod;
    } t_mul;

    typedef struct packed {
        logic [31:0] base;
        logic        neg;
        logic [31:0] dz;
        logic [31:0] rem;
        logic [31:0] nlo;
        logic [31:0] quo;
    } t_div;

    // one coordinate of an edge, low end taken by z
    function automatic t_lane edge_lane(
        input logic signed [31:0] lo_c,
        input logic signed [31:0] hi_c,
        input logic signed [31:0] lo_z,
        input logic signed [31:0] hi_z,
        input logic signed [31:0] h
    );
        t_lane            l;
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = {hi_c[31], hi_c} - {lo_c[31], lo_c};
        m = d[32] ? -d : d;
        l.base = lo_c;
        l.neg  = d[32];
        l.mag  = m[31:0];
        l.t    = 32'(h - lo_z);
        l.dz   = 32'(hi_z - lo_z);
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tps_front.sv =====
// ----------------------------------------------------------------------------
// tps_front
// ranks the vertices by z, checks the crossing and sets up both edges
// ----------------------------------------------------------------------------
`default_nettype none

module tps_front import tps_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_height,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    input  wire logic signed [31:0] i_cx,
    input  wire logic signed [31:0] i_cy,
    input  wire logic signed [31:0] i_cz,
    output logic                    o_push,
    input  wire logic               i_full,
    output t_item                   o_item
);

    logic               r_fv;
    t_item              r_item;
    t_item              n_item;
    logic signed [31:0] vx [3];
    logic signed [31:0] vy [3];
    logic signed [31:0] vz [3];
    logic signed [31:0] zmin;
    logic signed [31:0] zmax;
    logic [1:0]         lo;
    logic [1:0]         hi;
    logic [1:0]         mid;
    logic               lo_set;
    logic               hi_set;
    logic [1:0]         pv;
    logic [1:0]         e2lo;
    logic [1:0]         e2hi;
    logic               accept;

    assign o_stall = r_fv && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_fv && !i_full;
    assign o_item  = r_item;

    always_comb begin
        vx[0] = i_ax; vy[0] = i_ay; vz[0] = i_az;
        vx[1] = i_bx; vy[1] = i_by; vz[1] = i_bz;
        vx[2] = i_cx; vy[2] = i_cy; vz[2] = i_cz;
        zmin = vz[0];
        zmax = vz[0];
        for (int i = 1; i < 3; i++) begin
            if (vz[i] < zmin) zmin = vz[i];
            if (vz[i] > zmax) zmax = vz[i];
        end
        lo = 2'd0; hi = 2'd0; mid = 2'd0;
        lo_set = 1'b0; hi_set = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (vz[i] == zmin && !lo_set) begin
                lo = 2'(i); lo_set = 1'b1;
            end else if (vz[i] == zmax && !hi_set) begin
                hi = 2'(i); hi_set = 1'b1;
            end else begin
                mid = 2'(i);
            end
        end
        n_item.crosses = (zmin < zmax) && (zmin <= i_height) && (i_height <= zmax);
        pv = (vz[mid] > i_height) ? lo : hi;
        // edge low end: pivot only when strictly lower than middle
        e2lo = (vz[pv] < vz[mid]) ? pv : mid;
        e2hi = (vz[pv] < vz[mid]) ? mid : pv;
        n_item.lane[0] = edge_lane(vx[lo], vx[hi], vz[lo], vz[hi], i_height);
        n_item.lane[1] = edge_lane(vy[lo], vy[hi], vz[lo], vz[hi], i_height);
        n_item.lane[2] = edge_lane(vx[e2lo], vx[e2hi], vz[e2lo], vz[e2hi], i_height);
        n_item.lane[3] = edge_lane(vy[e2lo], vy[e2hi], vz[e2lo], vz[e2hi], i_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tps_queue.sv =====
// ----------------------------------------------------------------------------
// tps_queue
// short queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module tps_queue import tps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tps_back.sv =====
// ----------------------------------------------------------------------------
// tps_back
// multiply, pipelined restoring divide and offset add for four lanes
// ----------------------------------------------------------------------------
`default_nettype none

module tps_back import tps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [31:0] o_sx,
    output logic [31:0] o_sy,
    output logic [31:0] o_ex,
    output logic [31:0] o_ey,
    output logic        o_crosses
);

    logic                 en;
    logic                 r_vm;
    logic [DIV_STEPS:0]   r_vd;
    logic                 r_ov;
    t_mul                 r_mul [NUM_LANES];
    logic                 r_mcr;
    t_div                 r_div [DIV_STEPS+1][NUM_LANES];
    logic                 r_dcr [DIV_STEPS+1];
    logic [31:0]          r_res [NUM_LANES];
    logic                 r_ocr;
    logic [63:0]          num [NUM_LANES];
    logic [31:0]          n_res [NUM_LANES];

    function automatic t_div div_step(input t_div s);
        t_div        r;
        logic [32:0] sh;
        logic        ge;
        r  = s;
        sh = {s.rem, s.nlo[31]};
        ge = (sh >= {1'b0, s.dz});
        r.rem = ge ? 32'(sh - {1'b0, s.dz}) : sh[31:0];
        r.nlo = {s.nlo[30:0], 1'b0};
        r.quo = {s.quo[30:0], ge};
        return r;
    endfunction

    assign en      = !r_ov || !i_stall;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_sx    = r_res[0];
    assign o_sy    = r_res[1];
    assign o_ex    = r_res[2];
    assign o_ey    = r_res[3];
    assign o_crosses = r_ocr;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            num[l] = r_mul[l].prod + {33'b0, r_mul[l].dz[31:1]};
            if (!r_dcr[DIV_STEPS]) begin
                n_res[l] = '0;
            end else if (r_div[DIV_STEPS][l].dz == '0) begin
                n_res[l] = r_div[DIV_STEPS][l].base;
            end else if (r_div[DIV_STEPS][l].neg) begin
                n_res[l] = r_div[DIV_STEPS][l].base - r_div[DIV_STEPS][l].quo;
            end else begin
                n_res[l] = r_div[DIV_STEPS][l].base + r_div[DIV_STEPS][l].quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vd <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vm <= !i_empty;
            r_vd <= {r_vd[DIV_STEPS-1:0], r_vm};
            r_ov <= r_vd[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mcr <= i_item.crosses;
            r_dcr[0] <= r_mcr;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dcr[k] <= r_dcr[k-1];
            end
            r_ocr <= r_dcr[DIV_STEPS];
            for (int l = 0; l < NUM_LANES; l++) begin
                r_mul[l].base <= i_item.lane[l].base;
                r_mul[l].neg  <= i_item.lane[l].neg;
                r_mul[l].dz   <= i_item.lane[l].dz;
                r_mul[l].prod <= {32'b0, i_item.lane[l].mag} * {32'b0, i_item.lane[l].t};
                r_div[0][l].base <= r_mul[l].base;
                r_div[0][l].neg  <= r_mul[l].neg;
                r_div[0][l].dz   <= r_mul[l].dz;
                r_div[0][l].rem  <= num[l][63:32];
                r_div[0][l].nlo  <= num[l][31:0];
                r_div[0][l].quo  <= '0;
                for (int k = 1; k <= DIV_STEPS; k++) begin
                    r_div[k][l] <= div_step(r_div[k-1][l]);
                end
                r_res[l] <= n_res[l];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/triangle_plane_slice_core.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_slice_core
// slices triangles with the plane z = slice_height; without stalls it takes one triangle per cycle
// ----------------------------------------------------------------------------
// path from input transaction to output valid: front register, then queue,
//   multiplier, rounding add, 32 divider stages, output register
// throughput: one transaction per cycle through the pipelined divider when no stall holds it
// reset: synchronous active low, clears pipeline valids and slice_height to 0
`default_nettype none

module triangle_plane_slice_core import tps_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [31:0] i_vertex_a_x,
    input  wire logic signed [31:0] i_vertex_a_y,
    input  wire logic signed [31:0] i_vertex_a_z,
    input  wire logic signed [31:0] i_vertex_b_x,
    input  wire logic signed [31:0] i_vertex_b_y,
    input  wire logic signed [31:0] i_vertex_b_z,
    input  wire logic signed [31:0] i_vertex_c_x,
    input  wire logic signed [31:0] i_vertex_c_y,
    input  wire logic signed [31:0] i_vertex_c_z,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_seg_start_x,
    output logic signed [31:0] o_seg_start_y,
    output logic signed [31:0] o_seg_end_x,
    output logic signed [31:0] o_seg_end_y,
    output logic             o_crosses
);

    logic signed [31:0] r_slice_height;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    t_item              f_item;
    t_item              q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLICE_HEIGHT) ? r_slice_height : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_height <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_SLICE_HEIGHT) begin
            r_slice_height <= pwdata;
        end
    end

    tps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_height (r_slice_height),
        .i_ax     (i_vertex_a_x),
        .i_ay     (i_vertex_a_y),
        .i_az     (i_vertex_a_z),
        .i_bx     (i_vertex_b_x),
        .i_by     (i_vertex_b_y),
        .i_bz     (i_vertex_b_z),
        .i_cx     (i_vertex_c_x),
        .i_cy     (i_vertex_c_y),
        .i_cz     (i_vertex_c_z),
        .o_push   (push),
        .i_full   (full),
        .o_item   (f_item)
    );

    tps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    tps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_sx      (o_seg_start_x),
        .o_sy      (o_seg_start_y),
        .o_ex      (o_seg_end_x),
        .o_ey      (o_seg_end_y),
        .o_crosses (o_crosses)
    );

endmodule

`default_nettype wire
